>>> rtl/ert_pkg.sv
// Shared types and codes for the NEW-ENVIRON reply tokenizer.
// Used by ert_parser and environ_response_tokenizer_core; no dependencies.
`default_nettype none

package ert_pkg;

    // Protocol byte codes (RFC 1572)
    localparam logic [7:0] CODE_VAR     = 8'd0;
    localparam logic [7:0] CODE_VALUE   = 8'd1;
    localparam logic [7:0] CODE_ESC     = 8'd2;
    localparam logic [7:0] CODE_USERVAR = 8'd3;

    // Record type carried with every token
    localparam logic KIND_VAR     = 1'b0;
    localparam logic KIND_USERVAR = 1'b1;

    // Result queue depth; must be a power of two and at least 2
    localparam int ERT_FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        TK_NAME   = 3'd0,
        TK_VSTART = 3'd1,
        TK_VBYTE  = 3'd2,
        TK_END    = 3'd3,
        TK_DROP   = 3'd4
    } t_tok_kind;

    // One input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    // One result token
    typedef struct packed {
        t_tok_kind  token_kind;
        logic [7:0] token_byte;
        logic       record_kind;
        logic       last_of_run;
    } t_out;

    // Tokens produced by one accepted byte, slot 0 first
    typedef struct packed {
        t_out       res0;
        t_out       res1;
        logic [1:0] count;
    } t_emit;

endpackage

`default_nettype wire

>>> rtl/ert_parser.sv
// Byte parser: holds the record state and turns one body byte into up to two tokens.
// Depends on ert_pkg.
`default_nettype none

module ert_parser (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_accept,
    input  wire ert_pkg::t_in i_req,
    output ert_pkg::t_emit o_emit
);
    import ert_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP      = 3'd0,
        PH_TYPE      = 3'd1,
        PH_NAME      = 3'd2,
        PH_NAME_ESC  = 3'd3,
        PH_VALUE     = 3'd4,
        PH_VALUE_ESC = 3'd5
    } t_phase;

    t_phase r_phase, n_phase;
    logic   r_kind, n_kind;
    logic   r_name_seen, n_name_seen;
    logic   r_value_seen, n_value_seen;

    logic [7:0] b;
    logic       byte_tok_vld;
    t_out       byte_tok;
    logic       flush_tok_vld;
    t_out       flush_tok;
    logic       in_record;

    assign b = i_req.data_byte;

    // Byte step, then end-of-stream flush
    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_name_seen  = r_name_seen;
        n_value_seen = r_value_seen;
        byte_tok_vld = 1'b0;
        byte_tok     = '{token_kind: TK_NAME, token_byte: b, record_kind: r_kind,
                         last_of_run: 1'b0};
        flush_tok_vld = 1'b0;
        flush_tok     = '{token_kind: TK_END, token_byte: 8'd0, record_kind: r_kind,
                          last_of_run: 1'b0};

        case (r_phase)
            PH_SKIP: begin
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_kind       = (b == CODE_VAR) ? KIND_VAR : KIND_USERVAR;
                n_name_seen  = 1'b0;
                n_value_seen = 1'b0;
                n_phase      = PH_NAME;
            end
            PH_NAME, PH_VALUE: begin
                if (b == CODE_ESC) begin
                    n_phase = (r_phase == PH_NAME) ? PH_NAME_ESC : PH_VALUE_ESC;
                end else if (b == CODE_VAR || b == CODE_USERVAR) begin
                    // close current record, open a new one
                    byte_tok_vld          = 1'b1;
                    byte_tok.token_kind   = TK_END;
                    byte_tok.token_byte   = 8'd0;
                    n_kind       = (b == CODE_VAR) ? KIND_VAR : KIND_USERVAR;
                    n_name_seen  = 1'b0;
                    n_value_seen = 1'b0;
                    n_phase      = PH_NAME;
                end else if (b == CODE_VALUE && r_phase == PH_NAME) begin
                    byte_tok_vld        = 1'b1;
                    byte_tok.token_kind = TK_VSTART;
                    byte_tok.token_byte = 8'd0;
                    n_value_seen        = 1'b1;
                    n_phase             = PH_VALUE;
                end else if (r_phase == PH_NAME) begin
                    byte_tok_vld = 1'b1;
                    n_name_seen  = 1'b1;
                end else begin
                    byte_tok_vld        = 1'b1;
                    byte_tok.token_kind = TK_VBYTE;
                end
            end
            PH_NAME_ESC: begin
                byte_tok_vld = 1'b1;
                n_name_seen  = 1'b1;
                n_phase      = PH_NAME;
            end
            PH_VALUE_ESC: begin
                byte_tok_vld        = 1'b1;
                byte_tok.token_kind = TK_VBYTE;
                n_phase             = PH_VALUE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // flush looks at the state after the byte
        in_record = (n_phase == PH_NAME) || (n_phase == PH_NAME_ESC) ||
                    (n_phase == PH_VALUE) || (n_phase == PH_VALUE_ESC);
        if (i_req.end_of_stream) begin
            flush_tok.record_kind = n_kind;
            if (in_record && n_name_seen) begin
                flush_tok_vld        = 1'b1;
                flush_tok.token_kind = TK_END;
            end else if (in_record && n_value_seen) begin
                flush_tok_vld        = 1'b1;
                flush_tok.token_kind = TK_DROP;
            end
            n_phase      = PH_SKIP;
            n_kind       = KIND_VAR;
            n_name_seen  = 1'b0;
            n_value_seen = 1'b0;
        end
    end

    // Pack tokens into slots, mark the last one
    always_comb begin
        o_emit.res0  = byte_tok_vld ? byte_tok : flush_tok;
        o_emit.res1  = flush_tok;
        o_emit.count = {1'b0, byte_tok_vld} + {1'b0, flush_tok_vld};
        o_emit.res0.last_of_run = !(byte_tok_vld && flush_tok_vld);
        o_emit.res1.last_of_run = 1'b1;
    end

    // Record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SKIP;
            r_kind       <= KIND_VAR;
            r_name_seen  <= 1'b0;
            r_value_seen <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_name_seen  <= n_name_seen;
            r_value_seen <= n_value_seen;
        end
    end

endmodule

`default_nettype wire

>>> rtl/environ_response_tokenizer_core.sv
// NEW-ENVIRON IS/INFO reply tokenizer: top level with the result queue.
// Depends on ert_pkg and ert_parser.
//
// Usage:
//   Input channel (i_valid / o_stall / i_data) takes one body byte per request,
//   with end_of_stream set on the last byte of the body. Output channel
//   (o_valid / i_stall / o_data) delivers tokens in order; last_of_run marks
//   the final token caused by a byte.
//   The parser updates its state in the cycle the byte is taken and writes its
//   zero, one or two tokens into a 4-entry result queue. Each token is offered
//   on the output once it is in the queue and all earlier tokens have left.
//   Throughput: one byte per cycle while each byte makes at most one token and
//   the receiver does not stall; as the queue drains one token per cycle, a
//   byte that makes two tokens (byte token plus flush token) raises its fill.
//   o_stall rises when fewer than two queue entries are free, so a byte is
//   only accepted when room exists for everything it can produce.
//   When the receiver stalls, o_data holds and the queue fills; once it is
//   nearly full the input side is stalled.
//   Reset (synchronous, active low) empties the queue and returns the parser
//   to waiting for the reply kind byte.
`default_nettype none

module environ_response_tokenizer_core (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  wire ert_pkg::t_in i_data,
    output logic           o_valid,
    input  wire            i_stall,
    output ert_pkg::t_out  o_data
);
    import ert_pkg::*;

    localparam int PtrW = $clog2(ERT_FIFO_DEPTH);
    localparam int CntW = $clog2(ERT_FIFO_DEPTH + 1);
    localparam logic [CntW-1:0] StallLevel = CntW'(ERT_FIFO_DEPTH - 1);

    t_out            r_mem [ERT_FIFO_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    logic  accept;
    logic  pop;
    t_emit emit;

    assign accept = i_valid && !o_stall;
    assign pop    = o_valid && !i_stall;

    ert_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_data),
        .o_emit   (emit)
    );

    // Queue pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (accept) begin
            n_wr_ptr = r_wr_ptr + PtrW'(emit.count);
            n_count  = n_count + CntW'(emit.count);
        end
        if (pop) begin
            n_rd_ptr = r_rd_ptr + PtrW'(1);
            n_count  = n_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Token storage
    always_ff @(posedge i_clk) begin
        if (accept && emit.count != 2'd0) begin
            r_mem[r_wr_ptr] <= emit.res0;
        end
        if (accept && emit.count == 2'd2) begin
            r_mem[r_wr_ptr + PtrW'(1)] <= emit.res1;
        end
    end

    assign o_stall = (r_count >= StallLevel);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

`ifndef ASSERT_OFF
    // Queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(ERT_FIFO_DEPTH))
        else $error("result queue overflow");

    // Fill level tracks pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count)
            + ($past(accept) ? CntW'($past(emit.count)) : CntW'(0))
            - ($past(pop) ? CntW'(1) : CntW'(0)))
        else $error("result queue count mismatch");

    // Two tokens from one byte: only the second is marked last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit.count == 2'd2) |->
            (!emit.res0.last_of_run && emit.res1.last_of_run))
        else $error("last_of_run misplaced");
`endif

endmodule

`default_nettype wire

>>> tb/environ_response_tokenizer_core_test.sv
// Self-checking bench for environ_response_tokenizer_core: drives NEW-ENVIRON
// reply bytes and compares every token against an in-bench tokenizer model or a typed row.
// Depends on ert_pkg and the RTL of environ_response_tokenizer_core.
`timescale 1ns / 100ps

module environ_response_tokenizer_core_test;
    import ert_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 500000;
    localparam t_out  NO_TOK  = '0;
    localparam t_emit NO_EMIT = '0;

    // Parser phases of the bench model
    typedef enum logic [2:0] {
        PH_SKIP, PH_TYPE, PH_NAME, PH_NAME_ESC, PH_VALUE, PH_VALUE_ESC
    } t_parse_ph;

    // One request to send; typed rows carry their tokens spelled out
    typedef struct {
        t_in   req;
        bit    typed;
        t_emit want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    // Tokenizer model state
    t_parse_ph ph         = PH_SKIP;
    logic      rec_kind   = KIND_VAR;
    logic      name_open  = 1'b0;
    logic      value_open = 1'b0;

    t_stim_row  stim_q[$];
    logic [7:0] stream_bytes[$];
    t_out       token_q[$];
    int         n_directed;
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         stall_left  = 0;
    bit         tx_calm     = 1'b0;
    bit         rx_calm     = 1'b0;

    environ_response_tokenizer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out tok(t_tok_kind k, logic [7:0] v, logic rk, logic last);
        t_out t;
        t.token_kind  = k;
        t.token_byte  = v;
        t.record_kind = rk;
        t.last_of_run = last;
        return t;
    endfunction

    // A VAR byte opens a var record, anything else a user variable record
    function automatic void start_record(logic [7:0] b);
        rec_kind   = (b == CODE_VAR) ? KIND_VAR : KIND_USERVAR;
        name_open  = 1'b0;
        value_open = 1'b0;
        ph         = PH_NAME;
    endfunction

    function automatic void append_token(inout t_emit em, input t_tok_kind k,
                                         input logic [7:0] v);
        if (em.count == 2'd0) begin
            em.res0 = tok(k, v, rec_kind, 1'b0);
        end else begin
            em.res1 = tok(k, v, rec_kind, 1'b0);
        end
        em.count = em.count + 2'd1;
    endfunction

    // Advance the model by one body byte and return the tokens it makes
    function automatic t_emit tokenize_byte(t_in req);
        t_emit      em;
        logic [7:0] b;
        em = NO_EMIT;
        b  = req.data_byte;
        case (ph)
            PH_SKIP: ph = PH_TYPE;
            PH_TYPE: start_record(b);
            PH_NAME: begin
                if (b == CODE_ESC) begin
                    ph = PH_NAME_ESC;
                end else if (b == CODE_VAR || b == CODE_USERVAR) begin
                    append_token(em, TK_END, 8'h00);
                    start_record(b);
                end else if (b == CODE_VALUE) begin
                    append_token(em, TK_VSTART, 8'h00);
                    value_open = 1'b1;
                    ph         = PH_VALUE;
                end else begin
                    append_token(em, TK_NAME, b);
                    name_open = 1'b1;
                end
            end
            PH_NAME_ESC: begin
                append_token(em, TK_NAME, b);
                name_open = 1'b1;
                ph        = PH_NAME;
            end
            PH_VALUE: begin
                if (b == CODE_ESC) begin
                    ph = PH_VALUE_ESC;
                end else if (b == CODE_VAR || b == CODE_USERVAR) begin
                    append_token(em, TK_END, 8'h00);
                    start_record(b);
                end else begin
                    append_token(em, TK_VBYTE, b);
                end
            end
            PH_VALUE_ESC: begin
                append_token(em, TK_VBYTE, b);
                ph = PH_VALUE;
            end
            default: ;
        endcase
        // end of body: close a named record, drop a nameless one with a value
        if (req.end_of_stream) begin
            if (ph != PH_SKIP && ph != PH_TYPE) begin
                if (name_open) begin
                    append_token(em, TK_END, 8'h00);
                end else if (value_open) begin
                    append_token(em, TK_DROP, 8'h00);
                end
            end
            ph         = PH_SKIP;
            rec_kind   = KIND_VAR;
            name_open  = 1'b0;
            value_open = 1'b0;
        end
        if (em.count == 2'd1) begin
            em.res0.last_of_run = 1'b1;
        end else if (em.count == 2'd2) begin
            em.res1.last_of_run = 1'b1;
        end
        return em;
    endfunction

    function automatic void add_row(logic [7:0] b, logic eos, bit typed = 1'b0,
                                    t_emit want = '0);
        t_stim_row row;
        row.req.data_byte     = b;
        row.req.end_of_stream = eos;
        row.typed             = typed;
        row.want              = want;
        stim_q = {stim_q, row};
    endfunction

    // Append one byte to the body under construction
    function automatic void put_stream_byte(logic [7:0] v);
        stream_bytes = {stream_bytes, v};
    endfunction

    // Name or value content: mostly plain bytes, some escapes, literal VALUE in values
    function automatic void add_body_byte(bit in_value);
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) begin
            put_stream_byte(CODE_ESC);
            put_stream_byte(8'($urandom_range(0, 255)));
        end else if (r == 1 && in_value) begin
            put_stream_byte(CODE_VALUE);
        end else begin
            put_stream_byte(8'($urandom_range(4, 255)));
        end
    endfunction

    // One reply body: mostly well formed records, sometimes noise or cut short
    function automatic void add_stream();
        bit noisy;
        int cut;
        int nrec;
        int len;
        int r;
        stream_bytes.delete();
        noisy = ($urandom_range(0, 9) == 0);
        if (noisy) begin
            len = $urandom_range(1, 16);
            repeat (len) put_stream_byte(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                put_stream_byte(8'($urandom_range(0, 255)));
            end else begin
                put_stream_byte(8'($urandom_range(0, 1)));
            end
            r = $urandom_range(0, 9);
            if (r < 4) begin
                put_stream_byte(CODE_VAR);
            end else if (r < 9) begin
                put_stream_byte(CODE_USERVAR);
            end else begin
                put_stream_byte(8'($urandom_range(0, 255)));
            end
            nrec = $urandom_range(1, 4);
            for (int k = 0; k < nrec; k++) begin
                if (k > 0) begin
                    put_stream_byte($urandom_range(0, 1) ? CODE_USERVAR : CODE_VAR);
                end
                len = $urandom_range(0, 6);
                repeat (len) add_body_byte(1'b0);
                if ($urandom_range(0, 3) != 0) begin
                    put_stream_byte(CODE_VALUE);
                    len = $urandom_range(0, 6);
                    repeat (len) add_body_byte(1'b1);
                end
            end
            // escape left pending on the last byte
            if ($urandom_range(0, 7) == 0) begin
                put_stream_byte(CODE_ESC);
            end
        end
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, stream_bytes.size() - 1) : -1;
        for (int i = 0; i < stream_bytes.size(); i++) begin
            add_row(stream_bytes[i], (i == cut) || (i == stream_bytes.size() - 1) ||
                    (noisy && $urandom_range(0, 11) == 0));
        end
    endfunction

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int idle_len(inout bit calm);
        int r;
        if ($urandom_range(0, 49) == 0) begin
            calm = !calm;
        end
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_token(string why, t_out want, t_out got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected kind %0d byte %02h record %0b last %0b,",
                     why, want.token_kind, want.token_byte, want.record_kind,
                     want.last_of_run);
            $display("    got kind %0d byte %02h record %0b last %0b",
                     got.token_kind, got.token_byte, got.record_kind,
                     got.last_of_run);
        end
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            stall_left = idle_len(rx_calm);
        end
    end

    // Watchdog and token checker
    always @(posedge i_clk) begin
        t_out want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (token_q.size() == 0) begin
                report_token("unexpected token", NO_TOK, o_data);
            end else begin
                want = token_q.pop_front();
                if (o_data.token_kind !== want.token_kind ||
                    o_data.token_byte !== want.token_byte ||
                    o_data.record_kind !== want.record_kind ||
                    o_data.last_of_run !== want.last_of_run) begin
                    report_token("token mismatch", want, o_data);
                end
            end
        end
    end

    // Stimulus
    initial begin
        int        gap;
        t_emit     pred;
        t_stim_row row;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;

        // reply kind byte is skipped, then a var record with extreme name byte
        add_row(CODE_VAR, 1'b0, 1'b1, NO_EMIT);
        add_row(CODE_VAR, 1'b0, 1'b1, NO_EMIT);
        add_row(8'hFF, 1'b0, 1'b1, '{tok(TK_NAME, 8'hFF, KIND_VAR, 1'b1), NO_TOK, 2'd1});
        // escaped VALUE inside the name
        add_row(CODE_ESC, 1'b0);
        add_row(CODE_VALUE, 1'b0);
        // value start, then VALUE inside a value is a literal
        add_row(CODE_VALUE, 1'b0);
        add_row(CODE_VALUE, 1'b0);
        add_row(CODE_ESC, 1'b0);
        add_row(CODE_USERVAR, 1'b0);
        // USERVAR closes the var record
        add_row(CODE_USERVAR, 1'b0, 1'b1, '{tok(TK_END, 8'h00, KIND_VAR, 1'b1), NO_TOK, 2'd1});
        // empty user record closed mid-stream
        add_row(CODE_VAR, 1'b0, 1'b1,
                '{tok(TK_END, 8'h00, KIND_USERVAR, 1'b1), NO_TOK, 2'd1});
        add_row(8'h41, 1'b0);
        // last byte is a name byte: name token plus record end
        add_row(8'h80, 1'b1, 1'b1, '{tok(TK_NAME, 8'h80, KIND_VAR, 1'b0),
                                     tok(TK_END, 8'h00, KIND_VAR, 1'b1), 2'd2});
        // record closed by the last byte, new record empty so no flush token
        add_row(8'h02, 1'b0);
        add_row(8'h7E, 1'b0);
        add_row(CODE_VALUE, 1'b0);
        add_row(CODE_VAR, 1'b1);
        // flush with a value but no name: record dropped
        add_row(8'hA5, 1'b0);
        add_row(CODE_USERVAR, 1'b0);
        add_row(CODE_VALUE, 1'b0);
        add_row(8'h55, 1'b1, 1'b1, '{tok(TK_VBYTE, 8'h55, KIND_USERVAR, 1'b0),
                                     tok(TK_DROP, 8'h00, KIND_USERVAR, 1'b1), 2'd2});
        // pending escape discarded by the flush
        add_row(8'h00, 1'b0);
        add_row(CODE_VAR, 1'b0);
        add_row(8'h78, 1'b0);
        add_row(CODE_ESC, 1'b1, 1'b1, '{tok(TK_END, 8'h00, KIND_VAR, 1'b1), NO_TOK, 2'd1});
        // flush before any type byte, and on the type byte
        add_row(8'hFF, 1'b1, 1'b1, NO_EMIT);
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, NO_EMIT);
        n_directed = stim_q.size();

        while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
            add_stream();
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < stim_q.size(); idx++) begin
            row = stim_q[idx];
            // hold off until every outstanding token has come out
            if (idx == n_directed || idx == n_directed + RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                do @(negedge i_clk); while (token_q.size() != 0);
            end
            gap = idle_len(tx_calm);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= row.req;
            do @(posedge i_clk); while (o_stall !== 1'b0);
            pred = tokenize_byte(row.req);
            if (row.typed) begin
                pred = row.want;
            end
            if (pred.count > 2'd0) begin
                token_q = {token_q, pred.res0};
            end
            if (pred.count > 2'd1) begin
                token_q = {token_q, pred.res1};
            end
            @(negedge i_clk);
        end
        i_valid <= 1'b0;

        while (token_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
